FILE: hw/rtl/tcn_pkg.sv
// tcn_pkg: shared constants for the triangle condition number pipeline
// no dependencies; imported by every rtl file of the block
package tcn_pkg;

	localparam int OUT_W   = 32;
	localparam int QB      = 2 * OUT_W;
	localparam int CHUNK   = 32;
	localparam int MUL_LAT = 3;

	typedef logic [OUT_W-1:0] cond_t;

endpackage

FILE: hw/rtl/tcn_if.sv
// tcn_if: valid/ready channels for triangle items and condition results
// depends on tcn_pkg
interface tcn_in_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] ax;
	logic signed [COORD_WIDTH-1:0] ay;
	logic signed [COORD_WIDTH-1:0] bx;
	logic signed [COORD_WIDTH-1:0] by;
	logic signed [COORD_WIDTH-1:0] cx;
	logic signed [COORD_WIDTH-1:0] cy;

	modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
	modport sink (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface tcn_out_if import tcn_pkg::*;;
	logic  valid;
	logic  ready;
	cond_t cond_value;
	logic  degenerate;
	logic  saturated;

	modport source (output valid, cond_value, degenerate, saturated, input ready);
	modport sink (input valid, cond_value, degenerate, saturated, output ready);
endinterface

FILE: hw/rtl/tcn_mul.sv
// tcn_mul: unsigned multiplier from 32x32-bit partial products, three stages
// depends on tcn_pkg
module tcn_mul import tcn_pkg::*; #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);
	localparam int K  = (W + CHUNK - 1) / CHUNK;
	localparam int PW = CHUNK * K;
	localparam int RW = PW + CHUNK;

	logic [PW-1:0]      ap, bp;
	logic [2*CHUNK-1:0] pp_s1 [K][K];
	logic [RW-1:0]      row_d [K];
	logic [RW-1:0]      row_s2 [K];
	logic [2*PW-1:0]    acc_d;
	logic [2*W-1:0]     p_s3;

	assign ap = PW'(a);
	assign bp = PW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < K; i++) begin
				for (int j = 0; j < K; j++) begin
					pp_s1[i][j] <= ap[i*CHUNK +: CHUNK] * bp[j*CHUNK +: CHUNK];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < K; i++) begin
			row_d[i] = '0;
			for (int j = 0; j < K; j++) begin
				row_d[i] = row_d[i] + (RW'(pp_s1[i][j]) << (CHUNK * j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_d;
		end
	end

	always_comb begin
		acc_d = '0;
		for (int i = 0; i < K; i++) begin
			acc_d = acc_d + ((2*PW)'(row_s2[i]) << (CHUNK * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= acc_d[2*W-1:0];
		end
	end

	assign p = p_s3;
endmodule

FILE: hw/rtl/tcn_div.sv
// tcn_div: restoring divider, one quotient bit per pipeline stage
// depends on tcn_pkg; quotient is QB bits, caller guarantees it fits
module tcn_div import tcn_pkg::*; #(
	parameter int NW  = 166,
	parameter int DNW = 136
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NW-1:0]  num,
	input  logic [DNW-1:0] den,
	output logic [QB-1:0]  q
);
	localparam int RW = (NW > DNW + QB) ? NW : DNW + QB;

	logic [RW-1:0]  rem_s [QB-1];
	logic [DNW-1:0] den_s [QB-1];
	logic [QB-1:0]  q_s   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [RW-1:0]  rin, t, rdiff;
		logic [DNW-1:0] din;
		logic [QB-1:0]  qin, qnext;
		logic           ge;

		if (k == 0) begin : g_first
			assign rin = RW'(num);
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign din = den_s[k-1];
			assign qin = q_s[k-1];
		end

		always_comb begin
			t     = RW'(din) << (QB - 1 - k);
			ge    = (rin >= t);
			rdiff = rin - t;
			qnext = qin;
			qnext[QB-1-k] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= qnext;
			end
		end

		if (k < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? rdiff : rin;
					den_s[k] <= din;
				end
			end
		end
	end

	assign q = q_s[QB-1];
endmodule

FILE: hw/rtl/tcn_sqrt.sv
// tcn_sqrt: integer square root, one result bit per pipeline stage
// depends on tcn_pkg; QB-bit radicand, OUT_W-bit root
module tcn_sqrt import tcn_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [QB-1:0] y,
	output cond_t         r
);
	logic [QB-1:0] rem_s [OUT_W-1];
	logic [QB-1:0] res_s [OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [QB-1:0] yin, rin, trial, bitv, rnext;
		logic          ge;

		if (k == 0) begin : g_first
			assign yin = y;
			assign rin = '0;
		end else begin : g_next
			assign yin = rem_s[k-1];
			assign rin = res_s[k-1];
		end

		always_comb begin
			bitv  = QB'(1) << (QB - 2 - 2 * k);
			trial = rin + bitv;
			ge    = (yin >= trial);
			rnext = ge ? ((rin >> 1) + bitv) : (rin >> 1);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				res_s[k] <= rnext;
			end
		end

		if (k < OUT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? (yin - trial) : yin;
				end
			end
		end
	end

	assign r = res_s[OUT_W-1][OUT_W-1:0];
endmodule

FILE: hw/rtl/triangle_condition_number.sv
// triangle_condition_number: condition number quality of one 2D triangle per cycle
// depends on tcn_pkg, tcn_if, tcn_mul, tcn_div, tcn_sqrt
//
//   channel    dir  handshake        payload
//   tri_in     in   valid / ready    ax ay bx by cx cy (signed, COORD_WIDTH)
//   cond_out   out  valid / ready    cond_value[31:0] degenerate saturated
//
// one item per cycle while not held; 10 front stages (two three-stage
// multipliers), 64 divider stages, 32 square root stages, output register
// reset clears only the valid bits; payload registers are not reset
// the whole pipeline holds while the output register is full and not taken
module triangle_condition_number import tcn_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input logic        clk,
	input logic        arst_n,
	tcn_in_if.sink     tri_in,
	tcn_out_if.source  cond_out
);
	localparam int CW    = COORD_WIDTH;
	localparam int QW    = 2 * CW + 3;
	localparam int DMW   = 2 * CW + 1;
	localparam int NW    = 2 * QW + 2 * FRAC_BITS;
	localparam int DNW   = 2 * DMW + 4;
	localparam int CRW   = (NW > DNW + QB) ? NW : DNW + QB;
	localparam int P_MUL1 = 1 + MUL_LAT;
	localparam int P_D    = P_MUL1 + 1;
	localparam int P_MUL2 = P_D + MUL_LAT;
	localparam int P_ND   = P_MUL2 + 1;
	localparam int P_SAT  = P_ND + 1;
	localparam int P_DIV  = P_SAT + QB;
	localparam int P_SQ   = P_DIV + OUT_W;
	localparam int TOT    = P_SQ + 1;
	localparam int DL     = P_SQ - P_D + 1;
	localparam int SL     = P_SQ - P_SAT + 1;

	logic               en;
	logic [TOT:1]       vld_q;

	logic signed [CW:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic [CW-1:0]      mux, muy, mvx, mvy, mwx, mwy;
	logic [1:0]         sgn_q [MUL_LAT];
	logic [2*CW-1:0]    sq_ux, sq_uy, sq_vx, sq_vy, sq_wx, sq_wy, pr_p, pr_q;

	logic [QW-1:0]      twoq_d, twoq_s5;
	logic [DMW-1:0]     dm_d, dmag_s5;
	logic [2*QW-1:0]    nsq;
	logic [2*DMW-1:0]   dsq;
	logic [NW-1:0]      num_s9, num_s10;
	logic [DNW-1:0]     den_s9, den_s10;
	logic [QB-1:0]      quo;
	cond_t              root;

	logic               deg_q [DL];
	logic               sat_q [SL];
	cond_t              cond_q;
	logic               deg_out_q, sat_out_q;

	assign en           = ~vld_q[TOT] | cond_out.ready;
	assign tri_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-1:1], tri_in.valid};
		end
	end

	// edge vectors
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= (CW+1)'(tri_in.bx) - (CW+1)'(tri_in.ax);
			uy_s1 <= (CW+1)'(tri_in.by) - (CW+1)'(tri_in.ay);
			vx_s1 <= (CW+1)'(tri_in.cx) - (CW+1)'(tri_in.ax);
			vy_s1 <= (CW+1)'(tri_in.cy) - (CW+1)'(tri_in.ay);
			wx_s1 <= (CW+1)'(tri_in.bx) - (CW+1)'(tri_in.cx);
			wy_s1 <= (CW+1)'(tri_in.by) - (CW+1)'(tri_in.cy);
		end
	end

	function automatic logic [CW-1:0] magn(input logic signed [CW:0] x);
		logic [CW:0] m;
		m = x[CW] ? (CW+1)'(-x) : (CW+1)'(x);
		return m[CW-1:0];
	endfunction

	assign mux = magn(ux_s1);
	assign muy = magn(uy_s1);
	assign mvx = magn(vx_s1);
	assign mvy = magn(vy_s1);
	assign mwx = magn(wx_s1);
	assign mwy = magn(wy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_q[0] <= {ux_s1[CW] ^ vy_s1[CW], uy_s1[CW] ^ vx_s1[CW]};
			for (int i = 1; i < MUL_LAT; i++) begin
				sgn_q[i] <= sgn_q[i-1];
			end
		end
	end

	tcn_mul #(.W(CW)) u_sq_ux (.clk, .en, .a(mux), .b(mux), .p(sq_ux));
	tcn_mul #(.W(CW)) u_sq_uy (.clk, .en, .a(muy), .b(muy), .p(sq_uy));
	tcn_mul #(.W(CW)) u_sq_vx (.clk, .en, .a(mvx), .b(mvx), .p(sq_vx));
	tcn_mul #(.W(CW)) u_sq_vy (.clk, .en, .a(mvy), .b(mvy), .p(sq_vy));
	tcn_mul #(.W(CW)) u_sq_wx (.clk, .en, .a(mwx), .b(mwx), .p(sq_wx));
	tcn_mul #(.W(CW)) u_sq_wy (.clk, .en, .a(mwy), .b(mwy), .p(sq_wy));
	tcn_mul #(.W(CW)) u_pr_p  (.clk, .en, .a(mux), .b(mvy), .p(pr_p));
	tcn_mul #(.W(CW)) u_pr_q  (.clk, .en, .a(muy), .b(mvx), .p(pr_q));

	// 2q and determinant magnitude
	always_comb begin
		twoq_d = QW'(sq_ux) + QW'(sq_uy) + QW'(sq_vx) + QW'(sq_vy)
		       + QW'(sq_wx) + QW'(sq_wy);
		if (sgn_q[MUL_LAT-1][1] != sgn_q[MUL_LAT-1][0]) begin
			dm_d = DMW'(pr_p) + DMW'(pr_q);
		end else if (pr_p >= pr_q) begin
			dm_d = DMW'(pr_p - pr_q);
		end else begin
			dm_d = DMW'(pr_q - pr_p);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			twoq_s5 <= twoq_d;
			dmag_s5 <= dm_d;
			deg_q[0] <= (dm_d == '0);
			for (int i = 1; i < DL; i++) begin
				deg_q[i] <= deg_q[i-1];
			end
		end
	end

	tcn_mul #(.W(QW))  u_sq_q (.clk, .en, .a(twoq_s5), .b(twoq_s5), .p(nsq));
	tcn_mul #(.W(DMW)) u_sq_d (.clk, .en, .a(dmag_s5), .b(dmag_s5), .p(dsq));

	always_ff @(posedge clk) begin
		if (en) begin
			num_s9 <= NW'(nsq) << (2 * FRAC_BITS);
			den_s9 <= (DNW'(dsq) << 3) + (DNW'(dsq) << 2);
		end
	end

	// overflow when the quotient needs more than QB bits
	always_ff @(posedge clk) begin
		if (en) begin
			num_s10  <= num_s9;
			den_s10  <= den_s9;
			sat_q[0] <= (CRW'(num_s9) >= (CRW'(den_s9) << QB));
			for (int i = 1; i < SL; i++) begin
				sat_q[i] <= sat_q[i-1];
			end
		end
	end

	tcn_div #(.NW(NW), .DNW(DNW)) u_div (
		.clk, .en, .num(num_s10), .den(den_s10), .q(quo)
	);

	tcn_sqrt u_sqrt (.clk, .en, .y(quo), .r(root));

	always_ff @(posedge clk) begin
		if (en) begin
			cond_q    <= (deg_q[DL-1] | sat_q[SL-1]) ? '1 : root;
			deg_out_q <= deg_q[DL-1];
			sat_out_q <= sat_q[SL-1] & ~deg_q[DL-1];
		end
	end

	assign cond_out.valid      = vld_q[TOT];
	assign cond_out.cond_value = cond_q;
	assign cond_out.degenerate = deg_out_q;
	assign cond_out.saturated  = sat_out_q;
endmodule

FILE: tb/triangle_condition_number_tb.sv
// triangle_condition_number_tb: random and directed check of the condition number pipeline
// uses tcn_pkg, tcn_in_if, tcn_out_if and triangle_condition_number from hw/rtl
// an exact wide-integer predictor feeds a scoreboard that checks every result item in order
`timescale 1ns / 1ps

module triangle_condition_number_tb import tcn_pkg::*;;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int RAND_ITEMS  = 1600;
	localparam int DRAIN       = 120;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		coord_t ax, ay, bx, by, cx, cy;
	} tri_t;

	typedef struct packed {
		cond_t cond_value;
		logic  degenerate;
		logic  saturated;
	} cond_res_t;

	function automatic wide_t sx(coord_t v);
		return v;
	endfunction

	function automatic logic [31:0] isqrt(logic [63:0] y);
		logic [63:0] res;
		logic [63:0] bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > y) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (y >= res + bit_v) begin
				y = y - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res[31:0];
	endfunction

	function automatic cond_res_t predict_cond(tri_t t);
		wide_t ux, uy, vx, vy, wx, wy, s2, dd, num, den;
		cond_res_t r;
		ux = sx(t.bx) - sx(t.ax);
		uy = sx(t.by) - sx(t.ay);
		vx = sx(t.cx) - sx(t.ax);
		vy = sx(t.cy) - sx(t.ay);
		wx = sx(t.bx) - sx(t.cx);
		wy = sx(t.by) - sx(t.cy);
		s2 = ux * ux + uy * uy + vx * vx + vy * vy + wx * wx + wy * wy;
		dd = ux * vy - uy * vx;
		if (dd < 0) dd = -dd;
		r.cond_value = '1;
		r.degenerate = 1'b0;
		r.saturated  = 1'b0;
		if (dd == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		num = (s2 * s2) <<< (2 * FRAC_BITS);
		den = dd * dd * 12;
		if (num >= (den <<< 64)) begin
			r.saturated = 1'b1;
			return r;
		end
		num = num / den;
		r.cond_value = isqrt(num[63:0]);
		return r;
	endfunction

	class cond_scoreboard;
		cond_res_t pending[$];
		int n_degen, n_sat, n_plain;

		function void note_triangle(tri_t t);
			pending.push_back(predict_cond(t));
		endfunction

		function string check_result(cond_res_t got);
			cond_res_t exp_r;
			if (pending.size() == 0) return "result item with no triangle pending";
			exp_r = pending.pop_front();
			if (exp_r.degenerate) n_degen++;
			else if (exp_r.saturated) n_sat++;
			else n_plain++;
			if (got !== exp_r)
				return $sformatf("cond %h/%h degen %b/%b sat %b/%b (got/exp)",
					got.cond_value, exp_r.cond_value, got.degenerate, exp_r.degenerate,
					got.saturated, exp_r.saturated);
			return "";
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	int   send_pct = 0;
	int   recv_pct = 0;
	cond_scoreboard sb = new();

	tcn_in_if #(.COORD_WIDTH(COORD_WIDTH)) tri_in();
	tcn_out_if cond_out();

	triangle_condition_number #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tri_in   (tri_in.sink),
		.cond_out (cond_out.source)
	);

	always #10 clk = ~clk;

	initial begin
		tri_in.valid = 1'b0;
		tri_in.ax = '0; tri_in.ay = '0; tri_in.bx = '0;
		tri_in.by = '0; tri_in.cx = '0; tri_in.cy = '0;
		cond_out.ready = 1'b0;
	end

	task automatic report(string msg);
		errors++;
		$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		cond_res_t got;
		string msg;
		if (arst_n && cond_out.valid && cond_out.ready) begin
			got.cond_value = cond_out.cond_value;
			got.degenerate = cond_out.degenerate;
			got.saturated  = cond_out.saturated;
			msg = sb.check_result(got);
			if (msg != "") report(msg);
		end
	end

	always @(posedge clk) begin
		if (arst_n) cond_out.ready <= ($urandom_range(99) >= recv_pct);
	end

	task automatic send_triangle(tri_t t);
		while ($urandom_range(99) < send_pct) begin
			tri_in.valid <= 1'b0;
			@(posedge clk);
		end
		tri_in.valid <= 1'b1;
		tri_in.ax <= t.ax; tri_in.ay <= t.ay;
		tri_in.bx <= t.bx; tri_in.by <= t.by;
		tri_in.cx <= t.cx; tri_in.cy <= t.cy;
		do @(posedge clk); while (!tri_in.ready);
		sb.note_triangle(t);
	endtask

	function automatic coord_t rnd_coord();
		return $urandom;
	endfunction

	function automatic tri_t rnd_triangle();
		tri_t t;
		int k;
		int span;
		t.ax = rnd_coord();
		t.ay = rnd_coord();
		span = 1 << $urandom_range(30, 4);
		case ($urandom_range(9))
			0, 1: begin
				t.bx = rnd_coord(); t.by = rnd_coord();
				t.cx = rnd_coord(); t.cy = rnd_coord();
			end
			2: begin
				k = $urandom_range(4);
				t.bx = t.ax + coord_t'($urandom_range(span));
				t.by = t.ay + coord_t'($urandom_range(span));
				t.cx = t.ax + coord_t'(k) * (t.bx - t.ax);
				t.cy = t.ay + coord_t'(k) * (t.by - t.ay);
			end
			3: begin
				t.bx = t.ax; t.by = t.ay;
				t.cx = t.ax + coord_t'($urandom_range(1)); t.cy = t.ay;
			end
			4: begin
				t.bx = t.ax + coord_t'(span);
				t.by = t.ay + coord_t'($urandom_range(3));
				t.cx = t.ax + coord_t'($urandom_range(span));
				t.cy = t.ay + coord_t'($urandom_range(3));
			end
			default: begin
				t.ax = t.ax >>> $urandom_range(8);
				t.ay = t.ay >>> $urandom_range(8);
				t.bx = t.ax + coord_t'($urandom_range(span)) - coord_t'(span / 2);
				t.by = t.ay + coord_t'($urandom_range(span)) - coord_t'(span / 2);
				t.cx = t.ax + coord_t'($urandom_range(span)) - coord_t'(span / 2);
				t.cy = t.ay + coord_t'($urandom_range(span)) - coord_t'(span / 2);
			end
		endcase
		return t;
	endfunction

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		tri_t dir[$];
		coord_t mn, mx;
		mn = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		mx = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		dir.push_back('{0, 0, 65536, 0, 32768, 56756});
		dir.push_back('{0, 0, 65536, 0, 0, 65536});
		dir.push_back('{100, 100, 100, 100, 100, 100});
		dir.push_back('{0, 0, 65536, 65536, 131072, 131072});
		dir.push_back('{0, 0, 1 << 30, 0, 0, 1});
		dir.push_back('{0, 0, 1, 0, 0, 1});
		dir.push_back('{mn, mn, mx, mn, mn, mx});
		dir.push_back('{mx, mx, mn, mx, mx, mn});
		dir.push_back('{mn, mn, mx, mx, mn, mx});
		dir.push_back('{mn, mn, mn, mn, mn, mn});
		dir.push_back('{mx, mx, mx, mx, mx, mx});
		dir.push_back('{mn, mx, mx, mn, 0, 0});
		dir.push_back('{-1, -1, 0, -1, -1, 0});
		dir.push_back('{0, 0, mx, 0, 0, mx});
		dir.push_back('{mn, 0, mx, 0, 0, mx});
		dir.push_back('{-65536, 0, 65536, 0, 0, 113512});
		dir.push_back('{0, 0, 3, 1, 1, 3});
		dir.push_back('{mx, 0, mx, mx, 0, mx});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pct = 24;
		recv_pct = 51;
		foreach (dir[i]) send_triangle(dir[i]);
		for (int ph = 0; ph < 3; ph++) begin
			send_pct = (ph == 0) ? 24 : (ph == 1) ? 51 : 0;
			recv_pct = (ph == 0) ? 51 : (ph == 1) ? 24 : 0;
			repeat (RAND_ITEMS / 3) send_triangle(rnd_triangle());
		end
		tri_in.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d triangles: %0d regular, %0d degenerate, %0d saturated",
			sb.n_plain + sb.n_degen + sb.n_sat, sb.n_plain, sb.n_degen, sb.n_sat);
		$display("three stall profiles on both channels, %0d mismatches", errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
